>>> hdl/sma_pkg.sv
// Shared types and constants for the moving-average level meter.
// No dependencies; imported by sma_level and sample_moving_average_level.
package sma_pkg;

	// Threshold registers are fixed at 10 bits, four of them.
	localparam int LIMIT_W     = 10;
	localparam int LIMIT_COUNT = 4;
	localparam int CFG_IDX_W   = 2;

	// Level output: bands zero to four.
	localparam int LEVEL_W = 3;

	typedef logic [LIMIT_W-1:0]                  limit_t;
	typedef logic [LIMIT_COUNT-1:0][LIMIT_W-1:0] limit_set_t;
	typedef logic [LEVEL_W-1:0]                  level_t;

	// Reset values of the threshold registers, lowest band first.
	localparam limit_set_t LIMIT_RESET = {
		limit_t'(800), limit_t'(600), limit_t'(400), limit_t'(200)
	};

endpackage

>>> hdl/sma_cell.sv
// One storage cell of the sample window shift chain.
// Depends on nothing; instantiated by sample_moving_average_level.
module sma_cell #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic [SAMPLE_BITS-1:0] d,
	output logic [SAMPLE_BITS-1:0] q
);

	logic [SAMPLE_BITS-1:0] sample_q;

	// The window starts empty, so every cell resets to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

>>> hdl/sma_level.sv
// Output stage: registers the window average and its band index.
// Depends on sma_pkg; instantiated by sample_moving_average_level.
module sma_level
	import sma_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [SAMPLE_BITS-1:0] avg_in,
	input  limit_set_t             limits,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [SAMPLE_BITS-1:0] average,
	output level_t                 level
);

	localparam int CMP_W = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;

	logic [CMP_W-1:0]       avg_ext;
	level_t                 band;
	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] average_q;
	level_t                 level_q;

	// The first threshold that the average does not exceed gives the band.
	always_comb begin
		avg_ext = CMP_W'(avg_in);
		band    = level_t'(LIMIT_COUNT);
		for (int k = LIMIT_COUNT - 1; k >= 0; k--) begin
			if (avg_ext <= CMP_W'(limits[k])) begin
				band = level_t'(k);
			end
		end
	end

	// Result word is held until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			average_q <= avg_in;
			level_q   <= band;
		end
	end

	assign out_valid = valid_q;
	assign average   = average_q;
	assign level     = level_q;

endmodule

>>> hdl/sample_moving_average_level.sv
// Top level of the moving-average level meter.
// Depends on sma_pkg, sma_cell and sma_level.
//
// Usage:
//   Input channel (in_valid, in_ready, sample) takes one converter word per
//   cycle while in_ready is high. Output channel (out_valid, out_ready, average,
//   level) gives one word per input: the mean of the last 2**WINDOW_LOG2
//   samples and its band from zero to four against the four threshold registers.
//   Thresholds are written through cfg_we, cfg_addr and cfg_data; the user must
//   write them only while the block is idle, which the block does not enforce.
//   They take effect on the next result. An accepted word is registered in
//   the sum stage, then in the output register. Throughput: one word per cycle
//   while the receiver keeps up, set by the add and subtract on the running
//   sum and the shift of the cell chain. A stalled receiver holds the output
//   word; the input keeps accepting until the sum stage is also full, then
//   in_ready drops. Reset clears the sample chain and the running sum to zero,
//   so early averages include zeros, and loads thresholds 200, 400, 600, 800.
module sample_moving_average_level
	import sma_pkg::*;
#(
	parameter int WINDOW_LOG2 = 4,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_addr,
	input  logic [LIMIT_W-1:0]     cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] average,
	output level_t                 level
);

	localparam int WINDOW_LEN = 1 << WINDOW_LOG2;
	localparam int SUM_W      = SAMPLE_BITS + WINDOW_LOG2;

	limit_set_t             limits_q;
	logic                   valid_s1;
	logic [SUM_W-1:0]       sum_s1;
	logic                   out_free;
	logic                   accept;
	logic                   advance;
	logic [SAMPLE_BITS-1:0] chain [WINDOW_LEN+1];
	logic [SAMPLE_BITS-1:0] avg_s1;

	// Threshold registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limits_q[cfg_addr] <= cfg_data;
		end
	end

	// Handshake: the sum stage moves on when the output register is free.
	assign out_free = !out_valid || out_ready;
	assign in_ready = !valid_s1 || out_free;
	assign accept   = in_valid && in_ready;
	assign advance  = valid_s1 && out_free;

	// Sample window as a shift chain; the last cell holds the oldest word.
	assign chain[0] = sample;

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		sma_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (accept),
			.d     (chain[i]),
			.q     (chain[i+1])
		);
	end

	// Running sum gains the new word and drops the oldest one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sum_s1   <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				sum_s1   <= sum_s1 + SUM_W'(sample) - SUM_W'(chain[WINDOW_LEN]);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign avg_s1 = sum_s1[SUM_W-1:WINDOW_LOG2];

	// Band compare and output register.
	sma_level #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_level (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.avg_in   (avg_s1),
		.limits   (limits_q),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.average  (average),
		.level    (level)
	);

endmodule
